// ----- hw/rtl/reaction_combinatorial_factor_macros.svh -----
// Assertion macros shared by the reaction combinatorial factor RTL.
`ifndef REACTION_COMBINATORIAL_FACTOR_MACROS_SVH
`define REACTION_COMBINATORIAL_FACTOR_MACROS_SVH

// Condition must hold at every edge outside reset.
`define RCF_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RCF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/rcf_pkg.sv -----
// Shared widths, constants and types of the reaction combinatorial factor block.
package rcf_pkg;

  localparam int unsigned COUNT_W    = 31;
  localparam int unsigned STOICH_W   = 4;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned MAX_STOICH = 15;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_LOOP
  } rcf_kind_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [STOICH_W-1:0] k;
    rcf_kind_t           kind;
    logic                last;
  } rcf_item_t;

endpackage

// ----- hw/rtl/reaction_combinatorial_factor.sv -----
// Top level of the reaction combinatorial factor block: front end, queue and back end.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    molecule_count, stoichiometry, last_reactant
//   out_     output     out_valid/out_ready  combinatorial_factor, overflow, done_res
//
// A reactant that needs no loop goes straight to the back end's finish state; one
// with k loop iterations (k at most 15 after the symmetric reduction) runs the
// shared 32x32 multiplier (two partials per step, four for the product update) and the
// 8-bit-per-cycle divider.
// in_ready follows the queue only, so words are taken while the back end works.
// A finished result waits in the output register; the back end stalls only if a second
// result is due before it is taken. Synchronous reset returns the product to one.
module reaction_combinatorial_factor #(
  parameter int unsigned FIFO_DEPTH = rcf_pkg::FIFO_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rcf_pkg::COUNT_W-1:0]      in_molecule_count,
  input  logic [rcf_pkg::STOICH_W-1:0]     in_stoichiometry,
  input  logic                             in_last_reactant,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rcf_pkg::PROD_W-1:0]       out_combinatorial_factor,
  output logic                             out_overflow,
  output logic                             out_done_res
);

  logic               q_full;
  logic               q_empty;
  logic               q_wr_en;
  logic               q_rd_en;
  rcf_pkg::rcf_item_t q_wr_item;
  rcf_pkg::rcf_item_t q_rd_item;

  rcf_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_molecule_count (in_molecule_count),
    .in_stoichiometry  (in_stoichiometry),
    .in_last_reactant  (in_last_reactant),
    .q_full            (q_full),
    .q_wr_en           (q_wr_en),
    .q_wr_item         (q_wr_item)
  );

  rcf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_item (q_wr_item),
    .rd_en   (q_rd_en),
    .rd_item (q_rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  rcf_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .q_empty                  (q_empty),
    .q_rd_item                (q_rd_item),
    .q_rd_en                  (q_rd_en),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_combinatorial_factor (out_combinatorial_factor),
    .out_overflow             (out_overflow),
    .out_done_res             (out_done_res)
  );

endmodule

// ----- hw/rtl/rcf_front.sv -----
// Front end: accepts reactant words, clamps and classifies them into queue entries.
module rcf_front (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rcf_pkg::COUNT_W-1:0]    in_molecule_count,
  input  logic [rcf_pkg::STOICH_W-1:0]   in_stoichiometry,
  input  logic                           in_last_reactant,
  input  logic                           q_full,
  output logic                           q_wr_en,
  output rcf_pkg::rcf_item_t             q_wr_item
);

  logic [rcf_pkg::STOICH_W-1:0] rc;
  logic [rcf_pkg::COUNT_W-1:0]  rc_w;
  logic [rcf_pkg::COUNT_W-1:0]  n_half;

  assign in_ready = !q_full;
  assign q_wr_en  = in_valid && !q_full;

  always_comb begin
    rc = (32'(in_stoichiometry) > rcf_pkg::MAX_STOICH) ?
         rcf_pkg::STOICH_W'(rcf_pkg::MAX_STOICH) : in_stoichiometry;
    rc_w   = rcf_pkg::COUNT_W'(rc);
    n_half = in_molecule_count >> 1;

    q_wr_item.count = in_molecule_count;
    q_wr_item.last  = in_last_reactant;
    q_wr_item.k     = rc;
    if (rc_w > in_molecule_count) begin
      q_wr_item.kind = rcf_pkg::KIND_ZERO;
    end else if (rc == '0 || rc_w == in_molecule_count) begin
      q_wr_item.kind = rcf_pkg::KIND_ONE;
    end else begin
      q_wr_item.kind = rcf_pkg::KIND_LOOP;
      // symmetric reduction: n is below 2*rc here, so n - rc is narrow
      if (rc_w > n_half) begin
        q_wr_item.k = rcf_pkg::STOICH_W'(in_molecule_count - rc_w);
      end
    end
  end

endmodule

// ----- hw/rtl/rcf_fifo.sv -----
// Short queue of classified reactants between front end and back end.
`include "reaction_combinatorial_factor_macros.svh"

module rcf_fifo #(
  parameter int unsigned DEPTH = rcf_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  rcf_pkg::rcf_item_t wr_item,
  input  logic               rd_en,
  output rcf_pkg::rcf_item_t rd_item,
  output logic               full,
  output logic               empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rcf_pkg::rcf_item_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  `RCF_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, wr_en, !full, "push into full queue")
  `RCF_ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, rd_en, !empty, "pop from empty queue")
  `RCF_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CntW'(DEPTH), "queue count overrun")

endmodule

// ----- hw/rtl/rcf_div.sv -----
// Iterative divider of a 64-bit word by a 4-bit divisor, 8 quotient bits per cycle.
`include "reaction_combinatorial_factor_macros.svh"

module rcf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rcf_pkg::PROD_W-1:0]        dividend,
  input  logic [rcf_pkg::STOICH_W-1:0]      divisor,
  output logic                              done,
  output logic [rcf_pkg::PROD_W-1:0]        quotient
);

  localparam int unsigned DigitW = 8;
  localparam int unsigned Steps  = rcf_pkg::PROD_W / DigitW;
  localparam int unsigned StepW  = $clog2(Steps);
  localparam int unsigned DW     = rcf_pkg::STOICH_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [StepW-1:0]              cnt_r, cnt_nxt;
  logic [rcf_pkg::PROD_W-1:0]    dvd_r, dvd_nxt;
  logic [rcf_pkg::PROD_W-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]                 rem_r, rem_nxt;
  logic [DW-1:0]                 dsr_r, dsr_nxt;

  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    logic [DW-1:0]     r;
    logic [DW:0]       t;
    logic [DigitW-1:0] qd;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    r        = rem_r;
    qd       = '0;
    t        = '0;
    // one restoring step per quotient bit; the remainder stays below the divisor
    for (int j = 0; j < DigitW; j++) begin
      t = {r, dvd_r[rcf_pkg::PROD_W-1-j]};
      if (t >= {1'b0, dsr_r}) begin
        qd[DigitW-1-j] = 1'b1;
        r = DW'(t - {1'b0, dsr_r});
      end else begin
        r = t[DW-1:0];
      end
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << DigitW;
      quo_nxt = {quo_r[rcf_pkg::PROD_W-DigitW-1:0], qd};
      rem_nxt = r;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == StepW'(Steps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      dsr_r  <= DW'(1);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      dsr_r  <= dsr_nxt;
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  `RCF_ASSERT_IMPLIES(a_rem_below_dsr, clk, rst_n, busy_r, rem_r < dsr_r, "remainder not below divisor")
  `RCF_ASSERT_IMPLIES(a_div_nonzero, clk, rst_n, start, divisor != '0, "divide by zero started")

endmodule

// ----- hw/rtl/rcf_back.sv -----
// Back end: runs the binomial loop and the running product, drives the result register.
`include "reaction_combinatorial_factor_macros.svh"

module rcf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  rcf_pkg::rcf_item_t                q_rd_item,
  output logic                              q_rd_en,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcf_pkg::PROD_W-1:0]        out_combinatorial_factor,
  output logic                              out_overflow,
  output logic                              out_done_res
);

  localparam int unsigned PW  = rcf_pkg::PROD_W;
  localparam int unsigned HW  = PW / 2;
  localparam int unsigned AW  = 2 * PW;
  localparam int unsigned CW  = rcf_pkg::COUNT_W;
  localparam int unsigned SW  = rcf_pkg::STOICH_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [SW-1:0]     k_r, k_nxt;
  logic              last_r, last_nxt;
  logic [SW-1:0]     i_r, i_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;
  logic              ovf_r, ovf_nxt;
  logic [PW-1:0]     mul_a_r, mul_a_nxt;
  logic [PW-1:0]     mul_b_r, mul_b_nxt;
  logic [AW-1:0]     acc_r, acc_nxt;
  logic [1:0]        mstep_r, mstep_nxt;
  logic [1:0]        mlast_r, mlast_nxt;
  logic              final_r, final_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PW-1:0]     out_factor_r, out_factor_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              div_start;
  logic              div_done;
  logic [PW-1:0]     div_quo;

  rcf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r[PW-1:0]),
    .divisor  (i_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign q_rd_en                  = (state_r == ST_IDLE) && !q_empty;
  assign div_start                = (state_r == ST_CHK) && !final_r && (acc_r[AW-1:PW] == '0);
  assign out_valid                = out_valid_r;
  assign out_combinatorial_factor = out_factor_r;
  assign out_overflow             = out_ovf_r;
  assign out_done_res             = 1'b1;

  always_comb begin
    logic [HW-1:0] a_half;
    logic [HW-1:0] b_half;
    logic [PW-1:0] pp;
    logic [AW-1:0] pp_sh;
    state_nxt      = state_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    last_nxt       = last_r;
    i_nxt          = i_r;
    prod_nxt       = prod_r;
    ovf_nxt        = ovf_r;
    mul_a_nxt      = mul_a_r;
    mul_b_nxt      = mul_b_r;
    acc_nxt        = acc_r;
    mstep_nxt      = mstep_r;
    mlast_nxt      = mlast_r;
    final_nxt      = final_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_factor_nxt = out_factor_r;
    out_ovf_nxt    = out_ovf_r;

    // one 32x32 partial product per cycle: step bit 0 picks the half of a, bit 1 of b
    a_half = mstep_r[0] ? mul_a_r[PW-1:HW] : mul_a_r[HW-1:0];
    b_half = mstep_r[1] ? mul_b_r[PW-1:HW] : mul_b_r[HW-1:0];
    pp     = PW'(a_half) * PW'(b_half);
    case (2'(mstep_r[0]) + 2'(mstep_r[1]))
      2'd0:    pp_sh = AW'(pp);
      2'd1:    pp_sh = AW'(pp) << HW;
      default: pp_sh = AW'(pp) << PW;
    endcase

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          n_nxt    = q_rd_item.count;
          k_nxt    = q_rd_item.k;
          last_nxt = q_rd_item.last;
          state_nxt = ST_FIN;
          if (!ovf_r) begin
            case (q_rd_item.kind)
              rcf_pkg::KIND_ZERO: prod_nxt = '0;
              rcf_pkg::KIND_LOOP: begin
                // first iteration: res = 1, m = n
                i_nxt     = SW'(1);
                mul_a_nxt = PW'(1);
                mul_b_nxt = PW'(q_rd_item.count);
                acc_nxt   = '0;
                mstep_nxt = '0;
                mlast_nxt = 2'd1;
                final_nxt = 1'b0;
                state_nxt = ST_MUL;
              end
              default: ;
            endcase
          end
        end
      end
      ST_MUL: begin
        acc_nxt   = acc_r + pp_sh;
        mstep_nxt = mstep_r + 1'b1;
        if (mstep_r == mlast_r) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (acc_r[AW-1:PW] != '0) begin
          ovf_nxt   = 1'b1;
          prod_nxt  = '1;
          state_nxt = ST_FIN;
        end else if (final_r) begin
          prod_nxt  = acc_r[PW-1:0];
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          acc_nxt   = '0;
          mstep_nxt = '0;
          mul_a_nxt = div_quo;
          state_nxt = ST_MUL;
          if (i_r == k_r) begin
            // coefficient complete: fold it into the running product
            mul_a_nxt = prod_r;
            mul_b_nxt = div_quo;
            mlast_nxt = 2'd3;
            final_nxt = 1'b1;
          end else begin
            i_nxt     = i_r + 1'b1;
            mul_b_nxt = PW'(n_r - CW'(i_r));
            mlast_nxt = 2'd1;
          end
        end
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = prod_r;
          out_ovf_nxt    = ovf_r;
          prod_nxt       = PW'(1);
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prod_r      <= PW'(1);
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      mstep_r     <= '0;
      mlast_r     <= '0;
      final_r     <= 1'b0;
      i_r         <= SW'(1);
      k_r         <= SW'(1);
    end else begin
      state_r     <= state_nxt;
      prod_r      <= prod_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      mstep_r     <= mstep_nxt;
      mlast_r     <= mlast_nxt;
      final_r     <= final_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
    end
    n_r          <= n_nxt;
    last_r       <= last_nxt;
    mul_a_r      <= mul_a_nxt;
    mul_b_r      <= mul_b_nxt;
    acc_r        <= acc_nxt;
    out_factor_r <= out_factor_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  `RCF_ASSERT_IMPLIES(a_ovf_saturates, clk, rst_n, ovf_r, prod_r == '1, "overflow without saturated product")
  `RCF_ASSERT_IMPLIES(a_iter_range, clk, rst_n, state_r == ST_DIV, (i_r != '0) && (i_r <= k_r), "loop index out of range")
  `RCF_ASSERT_IMPLIES(a_mstep_range, clk, rst_n, state_r == ST_MUL, mstep_r <= mlast_r, "multiply step past last partial")

endmodule
